/* src/cntp_pkg.sv */
// Package for the checked number token parser.
// Character codes, token state flags and the result record shared by the step logic and top level.
// No dependencies.
package cntp_pkg;

  localparam logic [7:0] CHR_0     = 8'h30;
  localparam logic [7:0] CHR_9     = 8'h39;
  localparam logic [7:0] CHR_UPA   = 8'h41;
  localparam logic [7:0] CHR_UPF   = 8'h46;
  localparam logic [7:0] CHR_LOA   = 8'h61;
  localparam logic [7:0] CHR_LOF   = 8'h66;
  localparam logic [7:0] CHR_LOX   = 8'h78;
  localparam logic [7:0] CHR_UPX   = 8'h58;

  localparam logic [3:0] HEX_ALPHA_BASE = 4'd10;
  localparam int         OUT_WIDTH      = 32;

  typedef struct packed {
    logic [1:0] char_count;
    logic       first_was_zero;
    logic       hex_mode;
    logic       failed;
  } flags_t;

  typedef struct packed {
    logic                 is_number;
    logic [OUT_WIDTH-1:0] value;
  } result_t;

endpackage

/* src/checked_number_token_parse.sv */
// Checked number token parser: one character per transaction, tlast ends the token.
// A terminator passes through the input register (s1) and then the result register (out_res_r) to out_*.
// Throughput: one transaction per cycle, except while a terminator stalls in the input register.
// A terminator stalls in the input register only while the result register is held.
// Reset (rst_n low, synchronous) clears all token state and both valid flags.
// Depends on cntp_pkg and cntp_step.
module checked_number_token_parse #(
  parameter int VALUE_WIDTH = 32
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [7:0]  in_tdata,   // [7:0] chr
  input  logic        in_tlast,   // token_end
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [31:0] out_tdata,  // [31:0] value
  output logic        out_tuser   // [0] is_number
);

  logic                   s1_valid_r, s1_valid_nxt;
  logic [7:0]             s1_chr_r;
  logic                   s1_end_r;
  logic                   s1_adv;
  cntp_pkg::flags_t       flags_r, flags_nxt;
  logic [VALUE_WIDTH-1:0] accum_r, accum_nxt;
  cntp_pkg::result_t      step_res;
  logic                   out_valid_r, out_valid_nxt;
  cntp_pkg::result_t      out_res_r;

  cntp_step #(.VALUE_WIDTH(VALUE_WIDTH)) u_step (
    .flags     (flags_r),
    .accum     (accum_r),
    .chr       (s1_chr_r),
    .token_end (s1_end_r),
    .flags_nxt (flags_nxt),
    .accum_nxt (accum_nxt),
    .result    (step_res)
  );

  assign s1_adv    = s1_valid_r && (!s1_end_r || !out_valid_r || out_tready);
  assign in_tready = !s1_valid_r || s1_adv;

  always_comb begin
    s1_valid_nxt = s1_valid_r;
    if (in_tvalid && in_tready) begin
      s1_valid_nxt = 1'b1;
    end else if (s1_adv) begin
      s1_valid_nxt = 1'b0;
    end
    out_valid_nxt = out_valid_r;
    if (s1_adv && s1_end_r) begin
      out_valid_nxt = 1'b1;
    end else if (out_tready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
      flags_r     <= '0;
      accum_r     <= '0;
    end else begin
      s1_valid_r  <= s1_valid_nxt;
      out_valid_r <= out_valid_nxt;
      if (s1_adv) begin
        flags_r <= flags_nxt;
        accum_r <= accum_nxt;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_tvalid && in_tready) begin
      s1_chr_r <= in_tdata;
      s1_end_r <= in_tlast;
    end
    if (s1_adv && s1_end_r) begin
      out_res_r <= step_res;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_res_r.value;
  assign out_tuser  = out_res_r.is_number;

  a_value_zero_when_not_number: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tuser |-> out_tdata == 32'd0)
    else $error("non-number result carries a nonzero value");

  a_state_cleared_after_end: assert property (@(posedge clk) disable iff (!rst_n)
    s1_adv && s1_end_r |=> flags_r == '0 && accum_r == '0)
    else $error("token state not cleared after terminator");

  a_failed_sticky: assert property (@(posedge clk) disable iff (!rst_n)
    flags_r.failed && !(s1_adv && s1_end_r) |=> flags_r.failed)
    else $error("failure flag dropped inside a token");

  a_hex_needs_prefix: assert property (@(posedge clk) disable iff (!rst_n)
    flags_r.hex_mode |-> flags_r.char_count == 2'd2 && flags_r.first_was_zero)
    else $error("hex mode without a full prefix");

  a_no_result_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && !out_tready |-> !(s1_adv && s1_end_r))
    else $error("pending result overwritten");

endmodule

/* src/cntp_step.sv */
// Combinational per-character update of the token parser state.
// Depends on cntp_pkg for character codes, flags_t and result_t.
module cntp_step #(
  parameter int VALUE_WIDTH = 32
) (
  input  cntp_pkg::flags_t        flags,
  input  logic [VALUE_WIDTH-1:0]  accum,
  input  logic [7:0]              chr,
  input  logic                    token_end,
  output cntp_pkg::flags_t        flags_nxt,
  output logic [VALUE_WIDTH-1:0]  accum_nxt,
  output cntp_pkg::result_t       result
);

  localparam logic [VALUE_WIDTH-1:0] MAX_VAL = '1;
  localparam logic [VALUE_WIDTH-1:0] DEC_LIM = MAX_VAL / 10;
  localparam logic [3:0]             DEC_REM = 4'(MAX_VAL % 10);

  logic                   is_dec;
  logic                   is_upper;
  logic                   is_lower;
  logic                   is_x;
  logic [3:0]             digit;
  logic                   digit_ok;
  logic                   hex_ovf;
  logic                   dec_ovf;
  logic [VALUE_WIDTH-1:0] times_ten;
  logic [63:0]            accum_wide;

  assign accum_wide = 64'(accum);
  assign times_ten  = {accum[VALUE_WIDTH-4:0], 3'b000} + {accum[VALUE_WIDTH-2:0], 1'b0};
  assign hex_ovf    = accum[VALUE_WIDTH-1:VALUE_WIDTH-4] != 4'd0;
  assign dec_ovf    = (accum > DEC_LIM) || ((accum == DEC_LIM) && (digit > DEC_REM));

  always_comb begin
    is_dec   = chr inside {[cntp_pkg::CHR_0:cntp_pkg::CHR_9]};
    is_upper = chr inside {[cntp_pkg::CHR_UPA:cntp_pkg::CHR_UPF]};
    is_lower = chr inside {[cntp_pkg::CHR_LOA:cntp_pkg::CHR_LOF]};
    is_x     = (chr == cntp_pkg::CHR_LOX) || (chr == cntp_pkg::CHR_UPX);
    digit    = 4'd0;
    digit_ok = 1'b1;
    if (is_dec) begin
      digit = 4'(chr - cntp_pkg::CHR_0);
    end else if (flags.hex_mode && is_upper) begin
      digit = 4'(chr - cntp_pkg::CHR_UPA) + cntp_pkg::HEX_ALPHA_BASE;
    end else if (flags.hex_mode && is_lower) begin
      digit = 4'(chr - cntp_pkg::CHR_LOA) + cntp_pkg::HEX_ALPHA_BASE;
    end else begin
      digit_ok = 1'b0;
    end
  end

  always_comb begin
    flags_nxt        = flags;
    accum_nxt        = accum;
    result.is_number = 1'b0;
    result.value     = '0;
    if (token_end) begin
      result.is_number = (flags.char_count != 2'd0) && !flags.failed;
      result.value     = result.is_number ? accum_wide[cntp_pkg::OUT_WIDTH-1:0] : '0;
      flags_nxt        = '0;
      accum_nxt        = '0;
    end else begin
      if (flags.char_count != 2'd2) begin
        flags_nxt.char_count = flags.char_count + 2'd1;
      end
      if (!flags.failed) begin
        if (flags.char_count == 2'd0 && chr == cntp_pkg::CHR_0) begin
          flags_nxt.first_was_zero = 1'b1;
        end
        if (flags.char_count == 2'd1 && flags.first_was_zero && is_x) begin
          flags_nxt.hex_mode = 1'b1;
          accum_nxt          = '0;
        end else if (!digit_ok) begin
          flags_nxt.failed = 1'b1;
        end else if (flags.hex_mode) begin
          if (hex_ovf) begin
            flags_nxt.failed = 1'b1;
          end else begin
            accum_nxt = {accum[VALUE_WIDTH-5:0], digit};
          end
        end else begin
          if (dec_ovf) begin
            flags_nxt.failed = 1'b1;
          end else begin
            accum_nxt = times_ten + VALUE_WIDTH'(digit);
          end
        end
      end
    end
  end

endmodule

/* tb/sv/tb_checked_number_token_parse.sv */
// Testbench for checked_number_token_parse: directed and random tokens, with a local
// predictor of the parser and a scoreboard on the result stream.
// Depends on cntp_pkg and the checked_number_token_parse RTL.
module tb_checked_number_token_parse;

  localparam int          ITEMS_TOTAL = 1150;
  localparam int          QUIET_LIMIT = 5000;
  localparam logic [31:0] VALUE_MAX   = '1;

  logic        clk;
  logic        rst_n      = 1'b0;
  logic        in_tvalid  = 1'b0;
  logic        in_tready;
  logic [7:0]  in_tdata   = 8'd0;  // [7:0] chr
  logic        in_tlast   = 1'b0;  // token_end
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [31:0] out_tdata;          // [31:0] value
  logic        out_tuser;          // [0] is_number

  // parser state as predicted
  logic [1:0]  tok_pos;
  logic        tok_first_zero;
  logic        tok_hex;
  logic        tok_failed;
  logic [31:0] tok_accum;

  cntp_pkg::result_t expected_results[$];
  logic [7:0]  tok_chars[$];
  int          err_count  = 0;
  int          item_count = 0;
  int          stall_left = 0;
  bit          idle_en    = 1'b0;

  checked_number_token_parse u_top (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .in_tlast  (in_tlast),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata (out_tdata),
    .out_tuser (out_tuser)
  );

  always begin
    clk = 1'b0;
    #6;
    clk = 1'b1;
    #6;
  end

  function automatic void clear_token();
    tok_pos        = 2'd0;
    tok_first_zero = 1'b0;
    tok_hex        = 1'b0;
    tok_failed     = 1'b0;
    tok_accum      = '0;
  endfunction

  function automatic void add_digit(input logic [3:0] d);
    if (tok_hex) begin
      if (tok_accum > (VALUE_MAX >> 4))
        tok_failed = 1'b1;
      else
        tok_accum = {tok_accum[27:0], d};
    end else begin
      if (tok_accum > VALUE_MAX / 10 ||
          (tok_accum == VALUE_MAX / 10 && 32'(d) > VALUE_MAX % 10))
        tok_failed = 1'b1;
      else
        tok_accum = tok_accum * 10 + 32'(d);
    end
  endfunction

  function automatic void predict_parse(input logic [7:0] c, input logic term);
    logic [1:0]        pos;
    cntp_pkg::result_t r;
    pos = tok_pos;
    if (term) begin
      r.is_number = (pos != 2'd0) && !tok_failed;
      r.value     = r.is_number ? tok_accum : '0;
      expected_results.push_back(r);
      clear_token();
      return;
    end
    if (tok_pos < 2'd2)
      tok_pos = tok_pos + 2'd1;
    if (tok_failed)
      return;
    if (pos == 2'd0 && c == cntp_pkg::CHR_0)
      tok_first_zero = 1'b1;
    if (pos == 2'd1 && tok_first_zero &&
        (c == cntp_pkg::CHR_LOX || c == cntp_pkg::CHR_UPX)) begin
      tok_hex   = 1'b1;
      tok_accum = '0;
      return;
    end
    if (c >= cntp_pkg::CHR_0 && c <= cntp_pkg::CHR_9)
      add_digit(4'(c - cntp_pkg::CHR_0));
    else if (tok_hex && c >= cntp_pkg::CHR_UPA && c <= cntp_pkg::CHR_UPF)
      add_digit(4'(c - cntp_pkg::CHR_UPA) + cntp_pkg::HEX_ALPHA_BASE);
    else if (tok_hex && c >= cntp_pkg::CHR_LOA && c <= cntp_pkg::CHR_LOF)
      add_digit(4'(c - cntp_pkg::CHR_LOA) + cntp_pkg::HEX_ALPHA_BASE);
    else
      tok_failed = 1'b1;
  endfunction

  task automatic send_item(input logic [7:0] c, input logic term);
    int gap;
    if (idle_en && $urandom_range(0, 3) == 0) begin
      gap = $urandom_range(1, 16);
      @(negedge clk);
      in_tvalid <= 1'b0;
      repeat (gap - 1) @(negedge clk);
    end
    @(negedge clk);
    in_tvalid <= 1'b1;
    in_tdata  <= c;
    in_tlast  <= term;
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    predict_parse(c, term);
    item_count++;
  endtask

  // sends tok_chars followed by a terminator carrying a don't-care byte
  task automatic send_token();
    foreach (tok_chars[i])
      send_item(tok_chars[i], 1'b0);
    send_item(8'($urandom_range(0, 255)), 1'b1);
  endtask

  task automatic send_text(input string s);
    tok_chars.delete();
    for (int i = 0; i < s.len(); i++)
      tok_chars.push_back(s[i]);
    send_token();
  endtask

  task automatic append_text(input string s);
    for (int i = 0; i < s.len(); i++)
      tok_chars.push_back(s[i]);
  endtask

  task automatic gen_decimal();
    logic [39:0] big;
    int          zeros;
    tok_chars.delete();
    case ($urandom_range(0, 4))
      0: big = 40'($urandom_range(0, 999));
      1: big = 40'($urandom);
      2: big = 40'(VALUE_MAX - $urandom_range(0, 20));
      3: big = 40'(VALUE_MAX) + 40'($urandom_range(1, 10));
      default: big = 40'($urandom) * 10 + 40'($urandom_range(0, 9));
    endcase
    zeros = ($urandom_range(0, 4) == 0) ? $urandom_range(1, 3) : 0;
    repeat (zeros) tok_chars.push_back(cntp_pkg::CHR_0);
    append_text($sformatf("%0d", big));
  endtask

  task automatic gen_hex();
    logic [31:0] v;
    int          ndig;
    int          zeros;
    tok_chars.delete();
    tok_chars.push_back(cntp_pkg::CHR_0);
    tok_chars.push_back($urandom_range(0, 1) ? cntp_pkg::CHR_UPX : cntp_pkg::CHR_LOX);
    zeros = ($urandom_range(0, 4) == 0) ? $urandom_range(1, 3) : 0;
    repeat (zeros) tok_chars.push_back(cntp_pkg::CHR_0);
    ndig = $urandom_range(0, 9);
    v    = $urandom;
    if (ndig == 9) begin
      // one digit past the width
      append_text($sformatf("%0h", v | 32'h1000_0000));
      tok_chars.push_back(8'($urandom_range(cntp_pkg::CHR_0, cntp_pkg::CHR_9)));
    end else if (ndig > 0) begin
      if (ndig < 8)
        v = v & ((32'd1 << (4 * ndig)) - 32'd1);
      append_text($sformatf("%0h", v));
    end
    foreach (tok_chars[i])
      if (i > 1 && tok_chars[i] >= cntp_pkg::CHR_LOA &&
          tok_chars[i] <= cntp_pkg::CHR_LOF && $urandom_range(0, 1))
        tok_chars[i] = tok_chars[i] - cntp_pkg::CHR_LOA + cntp_pkg::CHR_UPA;
  endtask

  task automatic test_empty_and_prefix();
    send_text("");
    send_text("0x");
    send_text("0X");
    send_text("0");
    send_text("07");
  endtask

  task automatic test_decimal_limits();
    send_text("4294967295");
    send_text("4294967296");
    send_text("42949672950");
    send_text("0004294967295");
  endtask

  task automatic test_hex_limits();
    send_text("0xFFFFFFFF");
    send_text("0XaBcDeF09");
    send_text("0x100000000");
    send_text("0x00000000ffffffff");
  endtask

  task automatic test_invalid_chars();
    tok_chars.delete();
    tok_chars.push_back(8'h00);
    send_token();
    tok_chars.delete();
    tok_chars.push_back(8'hFF);
    send_token();
    send_text("1x");
    send_text("0xx");
    send_text("00x");
    send_text("ab");
    send_text("0a");
    send_text("12g3");
    send_text("0x1G");
  endtask

  task automatic test_random_tokens();
    int tok_idx;
    int pos;
    tok_idx = 0;
    while (item_count < ITEMS_TOTAL) begin
      idle_en = ((tok_idx / 40) % 2 == 0) && (item_count < ITEMS_TOTAL - 250);
      case ($urandom_range(0, 9))
        0, 1, 2, 3: gen_decimal();
        4, 5, 6:    gen_hex();
        7, 8: begin
          if ($urandom_range(0, 1)) gen_decimal();
          else gen_hex();
          pos = $urandom_range(0, tok_chars.size() - 1);
          tok_chars[pos] = $urandom_range(0, 1) ? cntp_pkg::CHR_LOX
                                                : 8'($urandom_range(0, 255));
        end
        default: begin
          tok_chars.delete();
          repeat ($urandom_range(0, 5)) tok_chars.push_back(8'($urandom_range(0, 255)));
        end
      endcase
      send_token();
      tok_idx++;
    end
  endtask

  always @(negedge clk) begin
    if (!idle_en) begin
      out_tready <= 1'b1;
    end else if (stall_left != 0) begin
      stall_left--;
      out_tready <= 1'b0;
    end else if ($urandom_range(0, 5) == 0) begin
      stall_left = $urandom_range(1, 16) - 1;
      out_tready <= 1'b0;
    end else begin
      out_tready <= 1'b1;
    end
  end

  always @(posedge clk) begin
    if (rst_n && out_tvalid && out_tready) begin
      if (expected_results.size() == 0) begin
        $error("unexpected result: is_number %0d, value %0d", out_tuser, out_tdata);
        err_count++;
      end else begin
        if (out_tuser !== expected_results[0].is_number) begin
          $error("is_number mismatch: expected %0d, actual %0d",
                 expected_results[0].is_number, out_tuser);
          err_count++;
        end
        if (out_tdata !== expected_results[0].value) begin
          $error("value mismatch: expected %0d, actual %0d",
                 expected_results[0].value, out_tdata);
          err_count++;
        end
        void'(expected_results.pop_front());
      end
    end
  end

  initial begin
    int quiet;
    quiet = 0;
    while (quiet < QUIET_LIMIT) begin
      @(posedge clk);
      if ((in_tvalid && in_tready) || (out_tvalid && out_tready))
        quiet = 0;
      else
        quiet++;
    end
    $display("DONE: errors detected");
    $finish;
  end

  initial begin
    clear_token();
    repeat (12) @(negedge clk);
    rst_n <= 1'b1;
    idle_en = 1'b1;
    test_empty_and_prefix();
    test_decimal_limits();
    test_hex_limits();
    test_invalid_chars();
    test_random_tokens();
    @(negedge clk);
    in_tvalid <= 1'b0;
    idle_en = 1'b0;
    while (expected_results.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
    if (err_count == 0 && expected_results.size() == 0)
      $display("DONE: 0 errors");
    else
      $display("DONE: errors detected");
    $finish;
  end

endmodule
